>>> hdl/pwlc_pkg.sv
// Shared types, constants and helpers for the piecewise linear curve table.
// Used by pwlc_front, pwlc_back and piecewise_linear_curve_lut.
package pwlc_pkg;

   localparam int NUM_POS = 256;
   localparam int POS_W   = 8;
   localparam int LVL_W   = 8;
   localparam int LAST    = NUM_POS - 1;
   localparam int CH_W    = 16;
   localparam int OFF_W   = 4;
   localparam int CI_W    = POS_W - OFF_W;
   localparam int NUM_W   = 2 * LVL_W;

   localparam logic [1:0] OP_SET    = 2'd0;
   localparam logic [1:0] OP_REMOVE = 2'd1;
   localparam logic [1:0] OP_CLEAR  = 2'd2;
   localparam logic [1:0] OP_EVAL   = 2'd3;

   typedef struct packed {
      logic [1:0]       opcode;
      logic [7:0]       position;
      logic [LVL_W-1:0] point_level;
   } req_type;

   typedef struct packed {
      logic [LVL_W-1:0] curve_level;
      logic             status;
   } rsp_type;

   typedef struct packed {
      logic [1:0]       op;
      logic [POS_W-1:0] pos;
      logic [LVL_W-1:0] level;
      logic             endpoint;
   } cmd_type;

   typedef struct packed {
      logic             found;
      logic [OFF_W-1:0] idx;
   } hit_type;

   // highest set bit of a chunk
   function automatic hit_type find_high(input logic [CH_W-1:0] v);
      hit_type h;
      h = '0;
      for (int i = 0; i < CH_W; i++) begin
         if (v[i]) begin
            h.found = 1'b1;
            h.idx   = OFF_W'(i);
         end
      end
      return h;
   endfunction

   // lowest set bit of a chunk
   function automatic hit_type find_low(input logic [CH_W-1:0] v);
      hit_type h;
      h = '0;
      for (int i = CH_W - 1; i >= 0; i--) begin
         if (v[i]) begin
            h.found = 1'b1;
            h.idx   = OFF_W'(i);
         end
      end
      return h;
   endfunction

endpackage

>>> hdl/pwlc_front.sv
// Front end: accepts requests, saturates and classifies them, and holds them
// in a two-entry queue for the back end. Depends on pwlc_pkg.
module pwlc_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  pwlc_pkg::req_type req_payload,
   output logic              cmd_valid,
   output pwlc_pkg::cmd_type cmd,
   input  logic              cmd_pop
);

   pwlc_pkg::cmd_type ent_ff [2];
   logic              wr_ptr_ff;
   logic              rd_ptr_ff;
   logic [1:0]        cnt_ff;
   logic [1:0]        cnt_in;
   pwlc_pkg::cmd_type cls;
   logic              push;

   // saturate the position and flag endpoints
   always_comb begin
      cls.op    = req_payload.opcode;
      cls.pos   = (int'(req_payload.position) > pwlc_pkg::LAST) ?
                  pwlc_pkg::POS_W'(pwlc_pkg::LAST) :
                  pwlc_pkg::POS_W'(req_payload.position);
      cls.level = req_payload.point_level;
      cls.endpoint = (cls.pos == '0) ||
                     (cls.pos == pwlc_pkg::POS_W'(pwlc_pkg::LAST));
   end

   assign req_ready = (cnt_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd       = ent_ff[rd_ptr_ff];

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !cmd_pop) cnt_in = cnt_ff + 2'd1;
      else if (!push && cmd_pop) cnt_in = cnt_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (cmd_pop) rd_ptr_ff <= !rd_ptr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (push) ent_ff[wr_ptr_ff] <= cls;
   end

endmodule

>>> hdl/pwlc_back.sv
// Back end: point store, neighbor search, interpolation and the result
// register. Depends on pwlc_pkg.
module pwlc_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  pwlc_pkg::cmd_type cmd,
   output logic              cmd_pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output pwlc_pkg::rsp_type rsp_payload
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_SRCH = 3'd1;
   localparam logic [2:0] ST_RDLO = 3'd2;
   localparam logic [2:0] ST_RDHI = 3'd3;
   localparam logic [2:0] ST_MULA = 3'd4;
   localparam logic [2:0] ST_MULB = 3'd5;
   localparam logic [2:0] ST_DIV  = 3'd6;

   localparam int PW = pwlc_pkg::POS_W;
   localparam int LW = pwlc_pkg::LVL_W;
   localparam int NW = pwlc_pkg::NUM_W;
   localparam int CW = pwlc_pkg::CH_W;
   localparam int OW = pwlc_pkg::OFF_W;
   localparam int IW = pwlc_pkg::CI_W;
   localparam logic [PW-1:0] LAST_POS = PW'(pwlc_pkg::LAST);
   localparam logic [pwlc_pkg::NUM_POS-1:0] PRESENT_DEFAULT =
      {1'b1, {(pwlc_pkg::NUM_POS-2){1'b0}}, 1'b1};

   logic [2:0]            state_ff;
   logic [pwlc_pkg::NUM_POS-1:0] present_ff;
   logic [LW-1:0]         ep_lo_ff, ep_hi_ff;
   logic [LW-1:0]         mem [pwlc_pkg::NUM_POS];
   logic [LW-1:0]         rd_q_ff;
   logic [PW-1:0]         rd_addr;
   logic                  mem_we;
   logic [PW-1:0]         idx_ff, lo_ff, hi_ff;
   logic [IW-1:0]         clo_ff, chi_ff;
   logic                  lo_found_ff, hi_found_ff, first_ff, direct_ff;
   logic [LW-1:0]         vlo_ff, vhi_ff;
   logic [NW-1:0]         prod_ff;
   logic [NW-1:0]         num;
   logic [LW-1:0]         rem_ff, numlo_ff, quo_ff;
   logic [2:0]            step_ff;
   logic                  rsp_valid_ff;
   pwlc_pkg::rsp_type     rsp_ff;
   logic [CW-1:0]         lo_mask, hi_mask;
   pwlc_pkg::hit_type     lo_hit, hi_hit;
   logic                  lo_done, hi_done;
   logic [LW-1:0]         den;
   logic [LW:0]           trial, diff;
   logic                  start;
   logic                  rsp_set;
   logic [LW-1:0]         picked;

   assign start       = (state_ff == ST_IDLE) && cmd_valid && (!rsp_valid_ff || rsp_ready);
   assign cmd_pop     = start;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // a result is ready after an edit, a direct hit or the last divide step
   assign rsp_set = (start && (cmd.op != pwlc_pkg::OP_EVAL)) ||
                    ((state_ff == ST_MULA) && direct_ff) ||
                    ((state_ff == ST_DIV) && (step_ff == 3'd7));

   // chunked neighbor search, one chunk per direction a cycle
   always_comb begin
      lo_mask = first_ff ? CW'((17'd2 << idx_ff[OW-1:0]) - 17'd1) : '1;
      hi_mask = first_ff ? ~lo_mask : '1;
      lo_hit  = pwlc_pkg::find_high(present_ff[clo_ff*CW +: CW] & lo_mask);
      hi_hit  = pwlc_pkg::find_low(present_ff[chi_ff*CW +: CW] & hi_mask);
      lo_done = lo_found_ff || lo_hit.found;
      hi_done = hi_found_ff || hi_hit.found;
   end

   // endpoints live in their own registers
   always_comb begin
      if (state_ff == ST_RDHI)
         picked = (lo_ff == '0) ? ep_lo_ff : (lo_ff == LAST_POS) ? ep_hi_ff : rd_q_ff;
      else
         picked = (hi_ff == '0) ? ep_lo_ff : (hi_ff == LAST_POS) ? ep_hi_ff : rd_q_ff;
   end

   assign den   = hi_ff - lo_ff;
   assign num   = prod_ff + NW'(vhi_ff) * NW'(idx_ff - lo_ff);
   assign trial = {rem_ff, numlo_ff[LW-1]};
   assign diff  = trial - {1'b0, den};

   assign rd_addr = (state_ff == ST_RDLO) ? lo_ff : hi_ff;
   assign mem_we  = start && (cmd.op == pwlc_pkg::OP_SET) && !cmd.endpoint;

   always_ff @(posedge clock) begin
      if (mem_we) mem[cmd.pos] <= cmd.level;
      rd_q_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         present_ff   <= PRESENT_DEFAULT;
         ep_lo_ff     <= '0;
         ep_hi_ff     <= '1;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_set) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  rsp_ff.curve_level <= '0;
                  rsp_ff.status      <= (cmd.op == pwlc_pkg::OP_REMOVE) && cmd.endpoint;
                  unique case (cmd.op)
                     pwlc_pkg::OP_SET: begin
                        present_ff[cmd.pos] <= 1'b1;
                        if (cmd.pos == '0) ep_lo_ff <= cmd.level;
                        else if (cmd.pos == LAST_POS) ep_hi_ff <= cmd.level;
                     end
                     pwlc_pkg::OP_REMOVE: begin
                        if (!cmd.endpoint) present_ff[cmd.pos] <= 1'b0;
                     end
                     pwlc_pkg::OP_CLEAR: begin
                        present_ff <= PRESENT_DEFAULT;
                        ep_lo_ff   <= '0;
                        ep_hi_ff   <= '1;
                     end
                     pwlc_pkg::OP_EVAL: begin
                        idx_ff      <= cmd.pos;
                        lo_ff       <= cmd.pos;
                        hi_ff       <= cmd.pos;
                        clo_ff      <= cmd.pos[PW-1:OW];
                        chi_ff      <= cmd.pos[PW-1:OW];
                        first_ff    <= 1'b1;
                        lo_found_ff <= 1'b0;
                        hi_found_ff <= 1'b0;
                        direct_ff   <= present_ff[cmd.pos];
                        state_ff    <= present_ff[cmd.pos] ? ST_RDLO : ST_SRCH;
                     end
                  endcase
               end
            end
            ST_SRCH: begin
               first_ff <= 1'b0;
               if (!lo_found_ff) begin
                  if (lo_hit.found) begin
                     lo_ff       <= {clo_ff, lo_hit.idx};
                     lo_found_ff <= 1'b1;
                  end else clo_ff <= clo_ff - IW'(1);
               end
               if (!hi_found_ff) begin
                  if (hi_hit.found) begin
                     hi_ff       <= {chi_ff, hi_hit.idx};
                     hi_found_ff <= 1'b1;
                  end else chi_ff <= chi_ff + IW'(1);
               end
               if (lo_done && hi_done) state_ff <= ST_RDLO;
            end
            ST_RDLO: state_ff <= ST_RDHI;
            ST_RDHI: begin
               vlo_ff   <= picked;
               state_ff <= ST_MULA;
            end
            ST_MULA: begin
               vhi_ff <= picked;
               if (direct_ff) begin
                  rsp_ff.curve_level <= vlo_ff;
                  state_ff           <= ST_IDLE;
               end else begin
                  prod_ff  <= NW'(vlo_ff) * NW'(hi_ff - idx_ff);
                  state_ff <= ST_MULB;
               end
            end
            ST_MULB: begin
               // quotient fits LVL_W bits, so the high half is below den
               rem_ff   <= num[NW-1:LW];
               numlo_ff <= num[LW-1:0];
               step_ff  <= '0;
               state_ff <= ST_DIV;
            end
            ST_DIV: begin
               rem_ff   <= diff[LW] ? trial[LW-1:0] : diff[LW-1:0];
               numlo_ff <= {numlo_ff[LW-2:0], 1'b0};
               quo_ff   <= {quo_ff[LW-2:0], !diff[LW]};
               step_ff  <= step_ff + 3'd1;
               if (step_ff == 3'd7) begin
                  rsp_ff.curve_level <= {quo_ff[LW-2:0], !diff[LW]};
                  state_ff           <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

>>> hdl/piecewise_linear_curve_lut.sv
// Piecewise linear curve table: top level joining front queue and back end.
// Set, remove and clear answer from the idle state; evaluate reads a present point
// from the store, else first searches (one 16-position chunk per direction a
// cycle), then 2 store reads, multiply states MULA and MULB and 8 divide steps.
// Throughput: one edit per cycle when results are taken, one evaluation at a time.
// Reset (synchronous): queue empty, points at first and last only, levels 0 and 255.
module piecewise_linear_curve_lut (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  pwlc_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output pwlc_pkg::rsp_type rsp_payload
);

   logic              cmd_valid;
   logic              cmd_pop;
   pwlc_pkg::cmd_type cmd;

   // accept and classify; queue decouples request side from execution
   pwlc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .cmd_valid   (cmd_valid),
      .cmd         (cmd),
      .cmd_pop     (cmd_pop)
   );

   // execute against the point store; hold each result until its transfer
   pwlc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cmd_valid   (cmd_valid),
      .cmd         (cmd),
      .cmd_pop     (cmd_pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   // never pop an empty queue
   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> cmd_valid) else $error("pop from empty queue");

   // a refused remove carries no level
   a_refuse_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.status) |-> (rsp_payload.curve_level == '0))
      else $error("refused result with nonzero level");

   // queue is empty and open right after reset
   a_reset_ready: assert property (@(posedge clock)
      reset |=> (req_ready && !rsp_valid)) else $error("not idle after reset");

endmodule

>>> dv/tb_piecewise_linear_curve_lut.sv
// Testbench for the piecewise linear curve table: drives set, remove, clear and
// evaluate requests and checks every response against an in-bench curve predictor.
// Depends on pwlc_pkg and piecewise_linear_curve_lut.
module tb_piecewise_linear_curve_lut;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 64;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   pwlc_pkg::req_type req_payload;
   logic              rsp_valid;
   logic              rsp_ready;
   pwlc_pkg::rsp_type rsp_payload;

   // predicted point store
   logic                       curve_present [pwlc_pkg::NUM_POS];
   logic [pwlc_pkg::LVL_W-1:0] curve_value   [pwlc_pkg::NUM_POS];

   pwlc_pkg::rsp_type expected_rsp_q[$];
   int      mismatch_count;
   int      rsp_count;
   int      idle_cycles;
   int      sender_idle_pct;
   int      receiver_idle_pct;
   bit      timed_out;
   int      op_count[4];

   piecewise_linear_curve_lut u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   // Restore the default two-point curve in the predictor.
   function automatic void load_default_curve();
      for (int p = 0; p < pwlc_pkg::NUM_POS; p++) begin
         curve_present[p] = 1'b0;
         curve_value[p]   = '0;
      end
      curve_present[0]              = 1'b1;
      curve_present[pwlc_pkg::LAST] = 1'b1;
      curve_value[pwlc_pkg::LAST]   = 8'd255;
   endfunction

   // Interpolate between the nearest present points around the index.
   function automatic logic [pwlc_pkg::LVL_W-1:0] curve_at(input int idx);
      int lo;
      int hi;
      int num;
      if (curve_present[idx]) return curve_value[idx];
      lo = idx;
      while (lo > 0 && !curve_present[lo]) lo--;
      hi = idx;
      while (hi < pwlc_pkg::LAST && !curve_present[hi]) hi++;
      if (hi == lo) return curve_value[lo];
      num = curve_value[lo] * (hi - idx) + curve_value[hi] * (idx - lo);
      return pwlc_pkg::LVL_W'(num / (hi - lo));
   endfunction

   // Apply one request to the predictor and return its response.
   function automatic pwlc_pkg::rsp_type apply_curve_request(input pwlc_pkg::req_type r);
      pwlc_pkg::rsp_type o;
      int                pos;
      o   = '0;
      pos = (r.position > pwlc_pkg::LAST) ? pwlc_pkg::LAST : int'(r.position);
      case (r.opcode)
         pwlc_pkg::OP_SET: begin
            curve_present[pos] = 1'b1;
            curve_value[pos]   = r.point_level;
         end
         pwlc_pkg::OP_REMOVE: begin
            if (pos == 0 || pos == pwlc_pkg::LAST) o.status = 1'b1;
            else curve_present[pos] = 1'b0;
         end
         pwlc_pkg::OP_CLEAR: load_default_curve();
         default: o.curve_level = curve_at(pos);
      endcase
      return o;
   endfunction

   // Hold a request until the transfer, then predict its response.
   task automatic send_request(input logic [1:0] op, input int pos, input int lvl);
      pwlc_pkg::req_type r;
      r.opcode      = op;
      r.position    = pos[7:0];
      r.point_level = lvl[7:0];
      while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_rsp_q.push_back(apply_curve_request(r));
      op_count[op]++;
      @(negedge clock);
   endtask

   task automatic wait_all_responses();
      req_valid <= 1'b0;
      while (expected_rsp_q.size() != 0) @(negedge clock);
   endtask

   // Randomize receiver stalls at each falling edge.
   always @(negedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= ($urandom_range(99) >= receiver_idle_pct);
   end

   // Check each response transfer against the oldest prediction.
   always @(posedge clock) begin
      pwlc_pkg::rsp_type exp_rsp;
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_count++;
         if (expected_rsp_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected response: level %0d status %0d",
                        rsp_payload.curve_level, rsp_payload.status);
         end else begin
            exp_rsp = expected_rsp_q.pop_front();
            if (rsp_payload.curve_level !== exp_rsp.curve_level ||
                rsp_payload.status !== exp_rsp.status) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: expected level %0d status %0d, got level %0d status %0d",
                           exp_rsp.curve_level, exp_rsp.status,
                           rsp_payload.curve_level, rsp_payload.status);
            end
         end
      end
   end

   // Watchdog: count cycles with no transfer on either channel.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else if (req_valid || expected_rsp_q.size() != 0) idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG_LIMIT && !timed_out) begin
         timed_out = 1'b1;
         $display("tb: failure");
         $finish;
      end
   end

   // Endpoints, range extremes, every opcode and each edit corner case.
   task automatic test_directed();
      send_request(pwlc_pkg::OP_EVAL, 0, 0);
      send_request(pwlc_pkg::OP_EVAL, 255, 0);
      send_request(pwlc_pkg::OP_EVAL, 128, 0);
      send_request(pwlc_pkg::OP_REMOVE, 0, 0);
      send_request(pwlc_pkg::OP_REMOVE, 255, 0);
      send_request(pwlc_pkg::OP_REMOVE, 77, 0);
      send_request(pwlc_pkg::OP_SET, 0, 255);
      send_request(pwlc_pkg::OP_SET, 255, 0);
      send_request(pwlc_pkg::OP_EVAL, 1, 0);
      send_request(pwlc_pkg::OP_SET, 100, 200);
      send_request(pwlc_pkg::OP_SET, 100, 37);
      send_request(pwlc_pkg::OP_EVAL, 100, 0);
      send_request(pwlc_pkg::OP_EVAL, 99, 0);
      send_request(pwlc_pkg::OP_EVAL, 170, 0);
      send_request(pwlc_pkg::OP_REMOVE, 100, 0);
      send_request(pwlc_pkg::OP_EVAL, 100, 0);
      send_request(pwlc_pkg::OP_SET, 100, 170);
      send_request(pwlc_pkg::OP_EVAL, 100, 0);
      send_request(pwlc_pkg::OP_SET, 1, 255);
      send_request(pwlc_pkg::OP_SET, 254, 255);
      send_request(pwlc_pkg::OP_EVAL, 2, 0);
      send_request(pwlc_pkg::OP_CLEAR, 0, 0);
      send_request(pwlc_pkg::OP_EVAL, 254, 0);
      send_request(pwlc_pkg::OP_EVAL, 100, 0);
   endtask

   // Build dense curves, then evaluate and edit them at random.
   task automatic test_random(input int n_items);
      int pick;
      for (int k = 0; k < n_items; k++) begin
         if (k == n_items / 2) begin
            // let the response side drain before going on
            wait_all_responses();
            sender_idle_pct   = 0;
            receiver_idle_pct = 0;
         end
         if (k == n_items / 2 + 300) begin
            sender_idle_pct   = 23;
            receiver_idle_pct = 23;
         end
         pick = $urandom_range(99);
         if (pick < 35)
            send_request(pwlc_pkg::OP_SET, $urandom_range(255), $urandom_range(255));
         else if (pick < 50)
            send_request(pwlc_pkg::OP_REMOVE, $urandom_range(255), $urandom);
         else if (pick < 52)
            send_request(pwlc_pkg::OP_CLEAR, $urandom, $urandom);
         else
            send_request(pwlc_pkg::OP_EVAL, $urandom_range(255), $urandom);
      end
   endtask

   initial begin
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_payload       = '0;
      rsp_ready         = 1'b0;
      sender_idle_pct   = 23;
      receiver_idle_pct = 23;
      load_default_curve();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_random(1926);
      wait_all_responses();
      repeat (DRAIN_CYCLES) @(negedge clock);
      $display("covered %0d sets, %0d removes, %0d clears, %0d evaluates; %0d responses",
               op_count[pwlc_pkg::OP_SET], op_count[pwlc_pkg::OP_REMOVE],
               op_count[pwlc_pkg::OP_CLEAR], op_count[pwlc_pkg::OP_EVAL], rsp_count);
      if (mismatch_count == 0 && expected_rsp_q.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("%0d mismatches, %0d responses missing", mismatch_count,
                  expected_rsp_q.size());
         $display("tb: failure");
      end
      $finish;
   end

endmodule
